// ----- hw/rtl/aavr_pkg.sv -----
// Package for the axis-angle vector rotation block.
// Word types, pipeline latencies and the CORDIC arctangent table.
// No dependencies.
package aavr_pkg;

   localparam int NORM_LAT   = 9;
   localparam int SQRT_LAT   = 32;
   localparam int DIV_LAT    = 31;
   localparam int MAT_LAT    = 7;
   localparam int TABLE_LEN  = 30;
   localparam int CORDIC_LAT = TABLE_LEN + 1;
   localparam int PIPE_LAT   = NORM_LAT + SQRT_LAT + DIV_LAT + MAT_LAT;

   localparam logic signed [33:0] Q30_ONE   = 34'sh040000000;
   localparam logic signed [33:0] HALF_TURN = 34'sh080000000;
   localparam logic signed [33:0] INV_GAIN  = 34'sh026DD3B6A;

   localparam logic [31:0] ATAN_TURN [TABLE_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   typedef struct packed {
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
      logic signed [31:0] axis_x;
      logic signed [31:0] axis_y;
      logic signed [31:0] axis_z;
      logic [15:0]        turn_angle;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } vec_type;

   // normalized axis magnitudes, signs and zero-axis flag
   typedef struct packed {
      logic [2:0][31:0] mag;
      logic [2:0]       neg;
      logic             zero;
   } axis_side_type;

endpackage

// ----- hw/rtl/aavr_delay.sv -----
// Shift-line delay for words that ride alongside the arithmetic stages.
// Uses no package.
module aavr_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [WIDTH-1:0] d_in,
   output logic [WIDTH-1:0] d_out
);

   logic [WIDTH-1:0] shift_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (enable) begin
         shift_ff[0] <= d_in;
         for (int k = 1; k < DEPTH; k++) begin
            shift_ff[k] <= shift_ff[k-1];
         end
      end
   end

   assign d_out = shift_ff[DEPTH-1];

endmodule

// ----- hw/rtl/aavr_axis_norm.sv -----
// Axis front end: magnitudes, common left shift, sum of squares.
// Depends on aavr_pkg.
module aavr_axis_norm
   import aavr_pkg::*;
(
   input  logic          clock,
   input  logic          enable,
   input  vec_type       axis_in,
   output axis_side_type side_out,
   output logic [63:0]   sum_out
);

   logic [2:0][31:0] mag0_ff;
   logic [2:0]       neg0_ff;
   logic [2:0][31:0] mag1_ff;
   logic [2:0]       neg1_ff;
   logic [31:0]      big1_ff;
   logic             zero1_ff;
   logic [2:0][31:0] mag_sh_ff [5];
   logic [31:0]      big_sh_ff [5];
   logic [2:0]       neg_sh_ff [5];
   logic             zero_sh_ff [5];
   logic [63:0]      sq_ff [3];
   axis_side_type    side7_ff;
   axis_side_type    side8_ff;
   logic [63:0]      sum_ff;
   logic [31:0]      a_in [3];
   logic [31:0]      big_in;

   assign a_in[0] = axis_in.x;
   assign a_in[1] = axis_in.y;
   assign a_in[2] = axis_in.z;

   always_comb begin
      big_in = mag0_ff[0];
      if (mag0_ff[1] > big_in) big_in = mag0_ff[1];
      if (mag0_ff[2] > big_in) big_in = mag0_ff[2];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 3; i++) begin
            neg0_ff[i] <= a_in[i][31];
            mag0_ff[i] <= a_in[i][31] ? (~a_in[i] + 32'd1) : a_in[i];
         end
         mag1_ff  <= mag0_ff;
         neg1_ff  <= neg0_ff;
         big1_ff  <= big_in;
         zero1_ff <= (big_in == 32'd0);
      end
   end

   for (genvar g = 0; g < 5; g++) begin : g_shift
      localparam int          SH  = 16 >> g;
      localparam logic [31:0] LIM = 32'd1 << (31 - SH);
      logic [2:0][31:0] mag_p;
      logic [31:0]      big_p;
      logic [2:0]       neg_p;
      logic             zero_p;
      if (g == 0) begin : g_first
         assign mag_p  = mag1_ff;
         assign big_p  = big1_ff;
         assign neg_p  = neg1_ff;
         assign zero_p = zero1_ff;
      end else begin : g_next
         assign mag_p  = mag_sh_ff[g-1];
         assign big_p  = big_sh_ff[g-1];
         assign neg_p  = neg_sh_ff[g-1];
         assign zero_p = zero_sh_ff[g-1];
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            neg_sh_ff[g]  <= neg_p;
            zero_sh_ff[g] <= zero_p;
            if (big_p < LIM) begin
               big_sh_ff[g] <= big_p << SH;
               for (int i = 0; i < 3; i++) mag_sh_ff[g][i] <= mag_p[i] << SH;
            end else begin
               big_sh_ff[g] <= big_p;
               mag_sh_ff[g] <= mag_p;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= 64'(mag_sh_ff[4][i]) * 64'(mag_sh_ff[4][i]);
         end
         side7_ff.mag  <= mag_sh_ff[4];
         side7_ff.neg  <= neg_sh_ff[4];
         side7_ff.zero <= zero_sh_ff[4];
         sum_ff        <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         side8_ff      <= side7_ff;
      end
   end

   assign side_out = side8_ff;
   assign sum_out  = sum_ff;

endmodule

// ----- hw/rtl/aavr_isqrt.sv -----
// Pipelined integer square root, one root bit per stage.
// Depends on aavr_pkg.
module aavr_isqrt
   import aavr_pkg::*;
(
   input  logic          clock,
   input  logic          enable,
   input  logic [63:0]   sum_in,
   input  axis_side_type side_in,
   output logic [31:0]   root_out,
   output axis_side_type side_out
);

   logic [33:0]   rem_ff  [SQRT_LAT];
   logic [31:0]   root_ff [SQRT_LAT];
   logic [63:0]   n_ff    [SQRT_LAT];
   axis_side_type side_ff [SQRT_LAT];

   for (genvar g = 0; g < SQRT_LAT; g++) begin : g_stage
      logic [33:0]   rem_p;
      logic [31:0]   root_p;
      logic [63:0]   n_p;
      axis_side_type side_p;
      logic [33:0]   rem2;
      logic [33:0]   trial;
      logic          ge;
      if (g == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign n_p    = sum_in;
         assign side_p = side_in;
      end else begin : g_next
         assign rem_p  = rem_ff[g-1];
         assign root_p = root_ff[g-1];
         assign n_p    = n_ff[g-1];
         assign side_p = side_ff[g-1];
      end
      assign rem2  = {rem_p[31:0], n_p[63-2*g -: 2]};
      assign trial = {root_p, 2'b01};
      assign ge    = (rem2 >= trial);
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[g]  <= ge ? (rem2 - trial) : rem2;
            root_ff[g] <= {root_p[30:0], ge};
            n_ff[g]    <= n_p;
            side_ff[g] <= side_p;
         end
      end
   end

   assign root_out = root_ff[SQRT_LAT-1];
   assign side_out = side_ff[SQRT_LAT-1];

endmodule

// ----- hw/rtl/aavr_divide.sv -----
// Three-lane pipelined restoring divider: |a| * 2^30 / r, one quotient bit per stage.
// Depends on aavr_pkg.
module aavr_divide
   import aavr_pkg::*;
(
   input  logic             clock,
   input  logic             enable,
   input  logic [31:0]      root_in,
   input  axis_side_type    side_in,
   output logic [2:0][30:0] quo_out,
   output axis_side_type    side_out
);

   logic [2:0][31:0] rem_ff  [DIV_LAT];
   logic [2:0][30:0] quo_ff  [DIV_LAT];
   logic [31:0]      root_ff [DIV_LAT];
   axis_side_type    side_ff [DIV_LAT];

   for (genvar t = 0; t < DIV_LAT; t++) begin : g_stage
      logic [2:0][31:0] rem_p;
      logic [2:0][30:0] quo_p;
      logic [2:0]       dbit;
      logic [31:0]      root_p;
      axis_side_type    side_p;
      if (t == 0) begin : g_first
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign rem_p[i] = {1'b0, side_in.mag[i][31:1]};
            assign dbit[i]  = side_in.mag[i][0];
         end
         assign quo_p  = '0;
         assign root_p = root_in;
         assign side_p = side_in;
      end else begin : g_next
         assign rem_p  = rem_ff[t-1];
         assign dbit   = '0;
         assign quo_p  = quo_ff[t-1];
         assign root_p = root_ff[t-1];
         assign side_p = side_ff[t-1];
      end
      for (genvar i = 0; i < 3; i++) begin : g_lane_op
         logic [32:0] rem2;
         logic        ge;
         assign rem2 = {rem_p[i], dbit[i]};
         assign ge   = (rem2 >= {1'b0, root_p});
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[t][i] <= ge ? 32'(rem2 - {1'b0, root_p}) : rem2[31:0];
               quo_ff[t][i] <= {quo_p[i][29:0], ge};
            end
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            root_ff[t] <= root_p;
            side_ff[t] <= side_p;
         end
      end
   end

   assign quo_out  = quo_ff[DIV_LAT-1];
   assign side_out = side_ff[DIV_LAT-1];

endmodule

// ----- hw/rtl/aavr_cordic.sv -----
// Rotation-mode CORDIC for cosine and sine, one iteration per stage.
// Depends on aavr_pkg.
module aavr_cordic
   import aavr_pkg::*;
#(
   parameter int STEPS = 16
) (
   input  logic               clock,
   input  logic               enable,
   input  logic [15:0]        angle_in,
   output logic signed [33:0] x_out,
   output logic signed [33:0] y_out,
   output logic               flip_out
);

   logic signed [33:0] x_ff    [CORDIC_LAT];
   logic signed [33:0] y_ff    [CORDIC_LAT];
   logic signed [33:0] z_ff    [CORDIC_LAT];
   logic               flip_ff [CORDIC_LAT];
   logic signed [33:0] z_in;

   assign z_in = {{2{angle_in[15]}}, angle_in, 16'h0000};

   // fold left half plane by a half turn
   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0] <= INV_GAIN;
         y_ff[0] <= '0;
         if (z_in >= Q30_ONE) begin
            z_ff[0]    <= z_in - HALF_TURN;
            flip_ff[0] <= 1'b1;
         end else if (z_in < -Q30_ONE) begin
            z_ff[0]    <= z_in + HALF_TURN;
            flip_ff[0] <= 1'b1;
         end else begin
            z_ff[0]    <= z_in;
            flip_ff[0] <= 1'b0;
         end
      end
   end

   for (genvar g = 1; g < CORDIC_LAT; g++) begin : g_stage
      if (g - 1 < STEPS) begin : g_iter
         logic signed [33:0] dx;
         logic signed [33:0] dy;
         logic signed [33:0] at;
         assign dx = y_ff[g-1] >>> (g - 1);
         assign dy = x_ff[g-1] >>> (g - 1);
         assign at = $signed({2'b00, ATAN_TURN[g-1]});
         always_ff @(posedge clock) begin
            if (enable) begin
               flip_ff[g] <= flip_ff[g-1];
               if (!z_ff[g-1][33]) begin
                  x_ff[g] <= x_ff[g-1] - dx;
                  y_ff[g] <= y_ff[g-1] + dy;
                  z_ff[g] <= z_ff[g-1] - at;
               end else begin
                  x_ff[g] <= x_ff[g-1] + dx;
                  y_ff[g] <= y_ff[g-1] - dy;
                  z_ff[g] <= z_ff[g-1] + at;
               end
            end
         end
      end else begin : g_hold
         always_ff @(posedge clock) begin
            if (enable) begin
               flip_ff[g] <= flip_ff[g-1];
               x_ff[g]    <= x_ff[g-1];
               y_ff[g]    <= y_ff[g-1];
               z_ff[g]    <= z_ff[g-1];
            end
         end
      end
   end

   assign x_out    = x_ff[CORDIC_LAT-1];
   assign y_out    = y_ff[CORDIC_LAT-1];
   assign flip_out = flip_ff[CORDIC_LAT-1];

endmodule

// ----- hw/rtl/aavr_matrix.sv -----
// Rodrigues matrix build, matrix-vector product, rounding and saturation.
// Depends on aavr_pkg.
module aavr_matrix
   import aavr_pkg::*;
(
   input  logic               clock,
   input  logic               enable,
   input  logic signed [33:0] x_in,
   input  logic signed [33:0] y_in,
   input  logic               flip_in,
   input  logic [2:0][30:0]   quo_in,
   input  axis_side_type      side_in,
   input  vec_type            vec_in,
   output rsp_type            rsp_out
);

   localparam logic signed [37:0] SAT_HI = 38'sd2147483647;
   localparam logic signed [37:0] SAT_LO = -38'sd2147483648;

   // M0
   logic signed [31:0] u0_ff [3];
   logic signed [31:0] c0_ff;
   logic signed [31:0] s0_ff;
   logic signed [32:0] omc0_ff;
   vec_type            v0_ff;
   // M1
   logic signed [31:0] uu1_ff [3][3];
   logic signed [31:0] us1_ff [3];
   logic signed [31:0] c1_ff;
   logic signed [32:0] omc1_ff;
   vec_type            v1_ff;
   // M2
   logic signed [32:0] w2_ff [3][3];
   logic signed [31:0] us2_ff [3];
   logic signed [31:0] c2_ff;
   vec_type            v2_ff;
   // M3
   logic signed [33:0] m3_ff [3][3];
   vec_type            v3_ff;
   // M4
   logic signed [63:0] p4_ff [3][3];
   // M5
   logic signed [37:0] t5_ff [3];
   // M6
   rsp_type            rsp_ff;

   logic signed [33:0] cx;
   logic signed [33:0] sy;
   logic signed [33:0] cc;
   logic signed [33:0] sc;
   logic signed [31:0] u_in [3];
   logic signed [31:0] v3 [3];
   logic signed [31:0] sat [3];
   logic [2:0]         clip;

   always_comb begin
      cx = flip_in ? -x_in : x_in;
      sy = flip_in ? -y_in : y_in;
      cc = (cx > Q30_ONE) ? Q30_ONE : ((cx < -Q30_ONE) ? -Q30_ONE : cx);
      sc = (sy > Q30_ONE) ? Q30_ONE : ((sy < -Q30_ONE) ? -Q30_ONE : sy);
      for (int i = 0; i < 3; i++) begin
         if (side_in.zero) u_in[i] = '0;
         else if (side_in.neg[i]) u_in[i] = -$signed({1'b0, quo_in[i]});
         else u_in[i] = $signed({1'b0, quo_in[i]});
      end
   end

   assign v3[0] = v3_ff.x;
   assign v3[1] = v3_ff.y;
   assign v3[2] = v3_ff.z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         clip[i] = 1'b0;
         if (t5_ff[i] > SAT_HI) begin
            sat[i]  = 32'sh7FFFFFFF;
            clip[i] = 1'b1;
         end else if (t5_ff[i] < SAT_LO) begin
            sat[i]  = 32'sh80000000;
            clip[i] = 1'b1;
         end else begin
            sat[i] = t5_ff[i][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      logic signed [63:0] pr;
      logic signed [64:0] pw;
      logic signed [65:0] pv;
      logic signed [65:0] acc;
      if (enable) begin
         // M0
         for (int i = 0; i < 3; i++) u0_ff[i] <= u_in[i];
         c0_ff   <= cc[31:0];
         s0_ff   <= sc[31:0];
         omc0_ff <= 33'(Q30_ONE) - 33'(cc);
         v0_ff   <= vec_in;
         // M1
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               pr = u0_ff[i] * u0_ff[j];
               uu1_ff[i][j] <= pr[61:30];
            end
            pr = u0_ff[i] * s0_ff;
            us1_ff[i] <= pr[61:30];
         end
         c1_ff   <= c0_ff;
         omc1_ff <= omc0_ff;
         v1_ff   <= v0_ff;
         // M2
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               pw = uu1_ff[i][j] * omc1_ff;
               w2_ff[i][j] <= pw[62:30];
            end
         end
         us2_ff <= us1_ff;
         c2_ff  <= c1_ff;
         v2_ff  <= v1_ff;
         // M3
         for (int i = 0; i < 3; i++) m3_ff[i][i] <= 34'(w2_ff[i][i]) + 34'(c2_ff);
         m3_ff[0][1] <= 34'(w2_ff[0][1]) - 34'(us2_ff[2]);
         m3_ff[1][0] <= 34'(w2_ff[1][0]) + 34'(us2_ff[2]);
         m3_ff[0][2] <= 34'(w2_ff[0][2]) + 34'(us2_ff[1]);
         m3_ff[2][0] <= 34'(w2_ff[2][0]) - 34'(us2_ff[1]);
         m3_ff[1][2] <= 34'(w2_ff[1][2]) - 34'(us2_ff[0]);
         m3_ff[2][1] <= 34'(w2_ff[2][1]) + 34'(us2_ff[0]);
         v3_ff <= v2_ff;
         // M4
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               pv = v3[j] * m3_ff[i][j];
               p4_ff[i][j] <= pv[65:2];
            end
         end
         // M5
         for (int i = 0; i < 3; i++) begin
            acc = 66'(p4_ff[i][0]) + 66'(p4_ff[i][1]) + 66'(p4_ff[i][2])
                + 66'sd134217728;
            t5_ff[i] <= acc[65:28];
         end
         // M6
         rsp_ff.out_x     <= sat[0];
         rsp_ff.out_y     <= sat[1];
         rsp_ff.out_z     <= sat[2];
         rsp_ff.saturated <= |clip;
      end
   end

   assign rsp_out = rsp_ff;

endmodule

// ----- hw/rtl/axis_angle_vector_rotation.sv -----
// Top level of the axis-angle (Rodrigues) vector rotation pipeline.
// Depends on aavr_pkg, aavr_delay, aavr_axis_norm, aavr_isqrt, aavr_divide,
// aavr_cordic and aavr_matrix.
//
//   channel  ports                            word
//   req      req_valid, req_stall, req_data   vector, axis, turn angle
//   rsp      rsp_valid, rsp_stall, rsp_data   rotated vector, saturated flag
//
// One word per cycle while no stalled result holds the pipe; the latency comes
// mostly from the 32-stage square root and the 31-stage divider on the axis
// path (CORDIC runs beside the divider).
// Reset clears only the stage valid bits.
// A stalled result freezes every stage; req_stall is raised for that cycle.
module axis_angle_vector_rotation
   import aavr_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [PIPE_LAT-1:0] valid_ff;
   logic                adv;
   vec_type             axis_in;
   vec_type             vec_in;
   vec_type             vec_dly;
   axis_side_type       side_n;
   axis_side_type       side_s;
   axis_side_type       side_d;
   logic [63:0]         sum_n;
   logic [31:0]         root_s;
   logic [2:0][30:0]    quo_d;
   logic [15:0]         angle_dly;
   logic signed [33:0]  cos_x;
   logic signed [33:0]  sin_y;
   logic                flip;

   assign adv       = !(valid_ff[PIPE_LAT-1] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = valid_ff[PIPE_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[PIPE_LAT-2:0], req_valid};
      end
   end

   assign axis_in.x = req_data.axis_x;
   assign axis_in.y = req_data.axis_y;
   assign axis_in.z = req_data.axis_z;
   assign vec_in.x  = req_data.vec_x;
   assign vec_in.y  = req_data.vec_y;
   assign vec_in.z  = req_data.vec_z;

   aavr_axis_norm u_norm (
      .clock    (clock),
      .enable   (adv),
      .axis_in  (axis_in),
      .side_out (side_n),
      .sum_out  (sum_n)
   );

   aavr_isqrt u_sqrt (
      .clock    (clock),
      .enable   (adv),
      .sum_in   (sum_n),
      .side_in  (side_n),
      .root_out (root_s),
      .side_out (side_s)
   );

   aavr_divide u_div (
      .clock    (clock),
      .enable   (adv),
      .root_in  (root_s),
      .side_in  (side_s),
      .quo_out  (quo_d),
      .side_out (side_d)
   );

   aavr_delay #(
      .WIDTH (16),
      .DEPTH (NORM_LAT + SQRT_LAT)
   ) u_angle_dly (
      .clock  (clock),
      .enable (adv),
      .d_in   (req_data.turn_angle),
      .d_out  (angle_dly)
   );

   aavr_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock    (clock),
      .enable   (adv),
      .angle_in (angle_dly),
      .x_out    (cos_x),
      .y_out    (sin_y),
      .flip_out (flip)
   );

   aavr_delay #(
      .WIDTH ($bits(vec_type)),
      .DEPTH (NORM_LAT + SQRT_LAT + DIV_LAT)
   ) u_vec_dly (
      .clock  (clock),
      .enable (adv),
      .d_in   (vec_in),
      .d_out  (vec_dly)
   );

   aavr_matrix u_mat (
      .clock   (clock),
      .enable  (adv),
      .x_in    (cos_x),
      .y_in    (sin_y),
      .flip_in (flip),
      .quo_in  (quo_d),
      .side_in (side_d),
      .vec_in  (vec_dly),
      .rsp_out (rsp_data)
   );

endmodule
